[hw/rtl/clamped_window_convolution_assert.svh]
// Assertion macros for the clamped window convolution block.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef CLAMPED_WINDOW_CONVOLUTION_ASSERT_SVH
`define CLAMPED_WINDOW_CONVOLUTION_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ccw_pkg.sv]
`default_nettype none

package ccw_pkg;

	localparam int KERNEL_SIZE_DEF    = 3;
	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int MAX_HEIGHT         = 4096;
	localparam int PIXEL_BITS         = 8;
	localparam int CHANNELS           = 3;
	localparam int COEF_W             = 16;
	localparam int COEF_IDX_W         = 4;
	localparam int FRAC_BITS          = 12;
	localparam int PROD_W             = PIXEL_BITS + 1 + COEF_W;
	localparam int ROW_W              = 12;
	localparam int SAT_W              = 14;
	localparam int WIDTH_REG_W        = 11;
	localparam int HEIGHT_REG_W       = 13;
	localparam int CFG_INDEX_W        = 2;
	localparam int CFG_DATA_W         = 13;
	localparam int FRAME_WIDTH_RESET  = 1024;
	localparam int FRAME_HEIGHT_RESET = 1024;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_COEF  = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [CHANNELS-1:0][PIXEL_BITS-1:0] rgb_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic shift;
		logic capture;
		logic sum;
	} lane_ctrl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} lb_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/ccw_line_buf.sv]
`default_nettype none

module ccw_line_buf import ccw_pkg::*; #(
	parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire lb_ctrl_t                     ctrl,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  wire rgb_t                         px,
	output rgb_t                              rd_data [KERNEL_SIZE-1]
);

	localparam int LINES = KERNEL_SIZE - 1;

	rgb_t rd_q [LINES];

	// Line 0 holds the newest row; each other line takes the row read from the line before it on write.
	for (genvar l = 0; l < LINES; l++) begin : g_line
		rgb_t mem [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (ctrl.rd_en) begin
				rd_q[l] <= mem[rd_addr];
			end
		end

		if (l == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (ctrl.wr_en) begin
					mem[wr_addr] <= px;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (ctrl.wr_en) begin
					mem[wr_addr] <= rd_q[l-1];
				end
			end
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[hw/rtl/ccw_lane.sv]
`default_nettype none

module ccw_lane import ccw_pkg::*; #(
	parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lane_ctrl_t ctrl,
	input  wire pixel_t     column [KERNEL_SIZE],
	input  wire coef_t      taps [KERNEL_SIZE*KERNEL_SIZE],
	output pixel_t          result
);

	localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
	localparam int ROW_SUM_W = PROD_W + $clog2(KERNEL_SIZE);
	localparam int ACC_W     = PROD_W + $clog2(TAPS);
	localparam int TOP_BIT   = FRAC_BITS + PIXEL_BITS;
	localparam logic [ACC_W:0] ROUND_HALF = (ACC_W+1)'(1) << (FRAC_BITS - 1);

	pixel_t window_q [KERNEL_SIZE][KERNEL_SIZE];
	pixel_t next_win [KERNEL_SIZE][KERNEL_SIZE];

	logic signed [PROD_W-1:0]    prod_d  [TAPS];
	logic signed [PROD_W-1:0]    prod_s2 [TAPS];
	logic signed [ROW_SUM_W-1:0] row_d   [KERNEL_SIZE];
	logic signed [ROW_SUM_W-1:0] row_s3  [KERNEL_SIZE];
	logic signed [ACC_W-1:0]     acc;
	logic        [ACC_W:0]       rnd;

	// Shift left by one column, new column enters on the right.
	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
				next_win[r][c] = window_q[r][c+1];
			end
			next_win[r][KERNEL_SIZE-1] = column[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE; c++) begin
					window_q[r][c] <= '0;
				end
			end
		end else if (ctrl.shift) begin
			window_q <= next_win;
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				prod_d[r*KERNEL_SIZE+c] = $signed({1'b0, next_win[r][c]}) *
					taps[r*KERNEL_SIZE+c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			prod_s2 <= prod_d;
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			row_d[r] = '0;
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				row_d[r] = row_d[r] + ROW_SUM_W'(prod_s2[r*KERNEL_SIZE+c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum) begin
			row_s3 <= row_d;
		end
	end

	// Round half up, drop the fraction, clamp to the pixel range.
	always_comb begin
		acc = '0;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			acc = acc + ACC_W'(row_s3[r]);
		end
		rnd = (ACC_W+1)'(acc) + ROUND_HALF;
		if (rnd[ACC_W]) begin
			result = '0;
		end else if (|rnd[ACC_W-1:TOP_BIT]) begin
			result = '1;
		end else begin
			result = rnd[TOP_BIT-1:FRAC_BITS];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/clamped_window_convolution.sv]
// Clamped window convolution: KxK correlation over a raster-order RGB stream.
// Input channel (in_valid/in_ready): with mode pixel, one RGB pixel per request,
// left to right, top to bottom; with mode coefficient, coef_value is written to
// tap coef_index (row*K + column), indexes beyond the kernel are dropped.
// Output channel (out_valid/out_ready): one filtered RGB pixel for each input
// pixel whose window lies inside the frame, frame_end on the last of a frame.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 frame width,
// index 1 frame height; writing either restarts the frame at its first pixel.
// Throughput: one request per cycle, pixel or coefficient, while the receiver
// takes results; set by the single read and single write of each line memory
// per cycle. A pixel passes stage one (line read), stage two (multiply), stage
// three (row sums), then the final sum and clamp into the output register.
// When the receiver stalls the output register holds; bubbles inside the
// pipeline still fill, so requests are taken until every stage is full.
// Reset clears window, taps and counters and restores 1024 x 1024; the line
// memories need no clearing since rows are written before they are used.
`default_nettype none

module clamped_window_convolution import ccw_pkg::*; #(
	parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   mode,
	input  wire pixel_t                 red_in,
	input  wire pixel_t                 green_in,
	input  wire pixel_t                 blue_in,
	input  wire logic [COEF_IDX_W-1:0]  coef_index,
	input  wire coef_t                  coef_value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output pixel_t                      red_out,
	output pixel_t                      green_out,
	output pixel_t                      blue_out,
	output logic                        frame_end,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int LINES = KERNEL_SIZE - 1;
	localparam int TAPS  = KERNEL_SIZE * KERNEL_SIZE;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WIDTH_RST = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
	localparam logic [COL_W-1:0] LAST_COL_RST = COL_W'(WIDTH_RST - 1);
	localparam logic [ROW_W-1:0] LAST_ROW_RST = ROW_W'(FRAME_HEIGHT_RESET - 1);
	localparam logic [COL_W-1:0] FIRST_COL_OUT = COL_W'(KERNEL_SIZE - 1);
	localparam logic [ROW_W-1:0] FIRST_ROW_OUT = ROW_W'(KERNEL_SIZE - 1);
	localparam logic [SAT_W-1:0] K_SAT  = SAT_W'(KERNEL_SIZE);
	localparam logic [SAT_W-1:0] MW_SAT = SAT_W'(MAX_WIDTH);
	localparam logic [SAT_W-1:0] MH_SAT = SAT_W'(MAX_HEIGHT);

	// Handshake and stage control
	logic in_accept, cfg_hit;
	logic s1_leave, s2_leave, s3_leave;
	logic s2_ready, s3_ready, out_free;
	logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

	// Frame position
	logic [COL_W-1:0] col_q, last_col_q, last_col_d;
	logic [ROW_W-1:0] row_q, last_row_q, last_row_d;
	logic [SAT_W-1:0] width_in, height_in, width_sat, height_sat;
	logic             at_row_end, at_frame_row, emit_d;

	// Stage one payload
	logic                  mode_s1, emit_s1, fe_s1;
	rgb_t                  px_s1;
	logic [COL_W-1:0]      col_s1;
	logic [COEF_IDX_W-1:0] cidx_s1;
	coef_t                 cval_s1;
	logic                  fe_s2, fe_s3;

	coef_t      taps_q [TAPS];
	rgb_t       line_rd [LINES];
	pixel_t     lane_col [CHANNELS][KERNEL_SIZE];
	pixel_t     lane_res [CHANNELS];
	lane_ctrl_t lane_ctrl;
	lb_ctrl_t   lb_ctrl;
	rgb_t       out_px_q;
	logic       out_fe_q;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
		cfg_index == REG_FRAME_HEIGHT);

	assign out_free = !out_valid_q || out_ready;
	assign s3_ready = !s3_valid_q || out_free;
	assign s2_ready = !s2_valid_q || s3_ready;
	assign s3_leave = s3_valid_q && out_free;
	assign s2_leave = s2_valid_q && s3_ready;
	// A request that yields no result needs no room further down.
	assign s1_leave = s1_valid_q && (s2_ready || !emit_s1);
	assign in_ready  = !s1_valid_q || s1_leave;
	assign in_accept = in_valid && in_ready;

	// Saturate configured sizes to the supported range.
	always_comb begin
		width_in  = SAT_W'(cfg_data[WIDTH_REG_W-1:0]);
		height_in = SAT_W'(cfg_data[HEIGHT_REG_W-1:0]);
		if (width_in < K_SAT) begin
			width_sat = K_SAT;
		end else if (width_in > MW_SAT) begin
			width_sat = MW_SAT;
		end else begin
			width_sat = width_in;
		end
		if (height_in < K_SAT) begin
			height_sat = K_SAT;
		end else if (height_in > MH_SAT) begin
			height_sat = MH_SAT;
		end else begin
			height_sat = height_in;
		end
		last_col_d = COL_W'(width_sat - SAT_W'(1));
		last_row_d = ROW_W'(height_sat - SAT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= LAST_COL_RST;
			last_row_q <= LAST_ROW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					last_col_q <= last_col_d;
				end
				REG_FRAME_HEIGHT: begin
					last_row_q <= last_row_d;
				end
				default: begin
				end
			endcase
		end
	end

	assign at_row_end   = (col_q == last_col_q);
	assign at_frame_row = (row_q == last_row_q);
	assign emit_d       = (col_q >= FIRST_COL_OUT) && (row_q >= FIRST_ROW_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept && mode == MODE_PIXEL) begin
			if (at_row_end) begin
				col_q <= '0;
				row_q <= at_frame_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_leave) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_leave && emit_s1) begin
				s2_valid_q <= 1'b1;
			end else if (s2_leave) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_leave) begin
				s3_valid_q <= 1'b1;
			end else if (s3_leave) begin
				s3_valid_q <= 1'b0;
			end
			if (s3_leave) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1 <= mode;
			emit_s1 <= (mode == MODE_PIXEL) && emit_d;
			fe_s1   <= at_row_end && at_frame_row;
			px_s1   <= {blue_in, green_in, red_in};
			col_s1  <= col_q;
			cidx_s1 <= coef_index;
			cval_s1 <= coef_value;
		end
		if (s1_leave && emit_s1) begin
			fe_s2 <= fe_s1;
		end
		if (s2_leave) begin
			fe_s3 <= fe_s2;
		end
		if (s3_leave) begin
			out_px_q <= {lane_res[2], lane_res[1], lane_res[0]};
			out_fe_q <= fe_s3;
		end
	end

	// Apply a tap write as it leaves stage one, behind earlier pixels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				taps_q[i] <= '0;
			end
		end else if (s1_leave && mode_s1 == MODE_COEF) begin
			for (int i = 0; i < TAPS; i++) begin
				if (int'(cidx_s1) == i) begin
					taps_q[i] <= cval_s1;
				end
			end
		end
	end

	assign lb_ctrl.rd_en = in_accept && mode == MODE_PIXEL;
	assign lb_ctrl.wr_en = s1_leave && mode_s1 == MODE_PIXEL;

	ccw_line_buf #(
		.KERNEL_SIZE(KERNEL_SIZE),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.ctrl   (lb_ctrl),
		.rd_addr(col_q),
		.wr_addr(col_s1),
		.px     (px_s1),
		.rd_data(line_rd)
	);

	// Oldest line at the top of the column, current pixel at the bottom.
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int r = 0; r < LINES; r++) begin
				lane_col[ch][r] = line_rd[LINES-1-r][ch];
			end
			lane_col[ch][KERNEL_SIZE-1] = px_s1[ch];
		end
	end

	assign lane_ctrl.shift   = s1_leave && mode_s1 == MODE_PIXEL;
	assign lane_ctrl.capture = s1_leave && emit_s1;
	assign lane_ctrl.sum     = s2_leave;

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		ccw_lane #(
			.KERNEL_SIZE(KERNEL_SIZE)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (lane_ctrl),
			.column(lane_col[ch]),
			.taps  (taps_q),
			.result(lane_res[ch])
		);
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_px_q[0];
	assign green_out = out_px_q[1];
	assign blue_out  = out_px_q[2];
	assign frame_end = out_fe_q;

endmodule

`default_nettype wire

[hw/rtl/ccw_checker.sv]
`default_nettype none

`include "clamped_window_convolution_assert.svh"

module ccw_checker import ccw_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   in_valid,
	input wire logic   in_ready,
	input wire logic   mode,
	input wire logic   out_valid,
	input wire logic   out_ready,
	input wire pixel_t red_out,
	input wire pixel_t green_out,
	input wire pixel_t blue_out,
	input wire logic   frame_end,
	input wire logic   cfg_valid,
	input wire logic   cfg_ready
);

	// A stalled result holds its value.
	`CCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_end), "stalled result changed")

	// A free output register lets every stage drain, so a request can enter.
	`CCW_ASSERT_NOW(a_in_ready_free, !out_valid || out_ready, in_ready, "input blocked with output free")

	// A tap write leaves stage one at once and never blocks the next request.
	`CCW_ASSERT_NEXT(a_coef_pass, in_valid && in_ready && mode == MODE_COEF, in_ready, "tap write stalled the input")

	`CCW_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind clamped_window_convolution ccw_checker u_ccw_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import ccw_pkg::*;

	localparam int K             = KERNEL_SIZE_DEF;
	localparam int LINES         = K - 1;
	localparam int TAP_COUNT     = K * K;
	localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);
	localparam int PIXEL_MAX     = (1 << PIXEL_BITS) - 1;
	localparam int PIPE_LATENCY  = 3;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int CALM_ITEMS    = 300;

	localparam logic [COEF_IDX_W-1:0] TAP_TOP_LEFT     = 4'd0;
	localparam logic [COEF_IDX_W-1:0] TAP_CENTRE       = 4'd4;
	localparam logic [COEF_IDX_W-1:0] TAP_BOTTOM_RIGHT = 4'd8;
	localparam logic [COEF_IDX_W-1:0] TAP_UNUSED       = 4'd15;

	localparam coef_t COEF_MAX  = 16'sh7FFF;
	localparam coef_t COEF_MIN  = 16'sh8000;
	localparam coef_t Q412_HALF = 16'sh0800;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef enum int {
		KERNEL_GENTLE,
		KERNEL_BLUR,
		KERNEL_WILD
	} kernel_style_t;

	typedef struct packed {
		pixel_t red;
		pixel_t green;
		pixel_t blue;
		logic   frame_end;
	} filtered_px_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic mode;
	pixel_t red_in, green_in, blue_in;
	logic [COEF_IDX_W-1:0] coef_index;
	coef_t coef_value;
	logic out_valid;
	logic out_ready;
	pixel_t red_out, green_out, blue_out;
	logic frame_end;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// filter state as the block should hold it
	rgb_t line_store [LINES][MAX_WIDTH_DEF] = '{default: '0};
	rgb_t window_px [TAP_COUNT] = '{default: '0};
	coef_t taps_q412 [TAP_COUNT] = '{default: '0};
	int unsigned next_col = 0;
	int unsigned next_row = 0;
	logic [WIDTH_REG_W-1:0] width_setting = WIDTH_REG_W'(FRAME_WIDTH_RESET);
	logic [HEIGHT_REG_W-1:0] height_setting = HEIGHT_REG_W'(FRAME_HEIGHT_RESET);

	filtered_px_t pending_pixels [$];

	int error_count = 0;
	int pixel_requests = 0;
	int coef_requests = 0;
	int register_writes = 0;
	int results_checked = 0;
	int frame_ends_seen = 0;
	int input_stall_cycles = 0;
	bit idling = 1'b1;
	bit long_hold = 1'b0;

	clamped_window_convolution uut (
		.clk, .arst_n,
		.in_valid, .in_ready, .mode, .red_in, .green_in, .blue_in, .coef_index, .coef_value,
		.out_valid, .out_ready, .red_out, .green_out, .blue_out, .frame_end,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	function automatic int unsigned active_width();
		if (width_setting < K) return K;
		if (width_setting > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return width_setting;
	endfunction

	function automatic int unsigned active_height();
		if (height_setting < K) return K;
		if (height_setting > MAX_HEIGHT) return MAX_HEIGHT;
		return height_setting;
	endfunction

	function automatic pixel_t convolve_channel(int ch);
		int acc, i, sample;
		acc = 0;
		for (i = 0; i < TAP_COUNT; i++) begin
			sample = window_px[i][ch];
			acc += sample * taps_q412[i];
		end
		acc += ROUND_HALF;
		if (acc < 0) return '0;
		acc = acc >>> FRAC_BITS;
		if (acc > PIXEL_MAX) return pixel_t'(PIXEL_MAX);
		return pixel_t'(acc);
	endfunction

	task automatic apply_request(logic m, rgb_t px, logic [COEF_IDX_W-1:0] idx, coef_t val);
		int unsigned w, h, col, row;
		int r, c;
		rgb_t column_px [K];
		filtered_px_t res;
		w = active_width();
		h = active_height();
		if (m == MODE_COEF) begin
			if (idx < TAP_COUNT) taps_q412[idx] = val;
			return;
		end
		col = (next_col >= w) ? w - 1 : next_col;
		row = next_row;
		// oldest line on top, incoming pixel at the bottom
		for (r = 0; r < LINES; r++) column_px[r] = line_store[LINES - 1 - r][col];
		column_px[LINES] = px;
		for (r = LINES - 1; r > 0; r--) line_store[r][col] = line_store[r - 1][col];
		line_store[0][col] = px;
		for (r = 0; r < K; r++) begin
			for (c = 0; c < K - 1; c++) window_px[r * K + c] = window_px[r * K + c + 1];
			window_px[r * K + K - 1] = column_px[r];
		end
		if (col >= K - 1 && row >= K - 1) begin
			res.red       = convolve_channel(0);
			res.green     = convolve_channel(1);
			res.blue      = convolve_channel(2);
			res.frame_end = (col == w - 1 && row >= h - 1);
			pending_pixels.push_back(res);
		end
		if (col + 1 >= w) begin
			next_col = 0;
			next_row = (row + 1 >= h) ? 0 : row + 1;
		end else
			next_col = col + 1;
	endtask

	task automatic send_request(logic m, pixel_t r, pixel_t g, pixel_t b,
			logic [COEF_IDX_W-1:0] idx, coef_t val);
		rgb_t px;
		if (idling && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 10)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		@(negedge clk);
		in_valid   <= 1'b1;
		mode       <= m;
		red_in     <= r;
		green_in   <= g;
		blue_in    <= b;
		coef_index <= idx;
		coef_value <= val;
		do @(posedge clk); while (!in_ready);
		px[0] = r;
		px[1] = g;
		px[2] = b;
		apply_request(m, px, idx, val);
		if (m == MODE_COEF) coef_requests++;
		else pixel_requests++;
	endtask

	task automatic send_pixel(pixel_t r, pixel_t g, pixel_t b);
		logic [COEF_IDX_W-1:0] idx;
		idx = COEF_IDX_W'($urandom);
		send_request(MODE_PIXEL, r, g, b, idx, coef_t'($urandom));
	endtask

	task automatic send_random_pixel();
		send_pixel(pixel_t'($urandom), pixel_t'($urandom), pixel_t'($urandom));
	endtask

	task automatic send_coef(logic [COEF_IDX_W-1:0] idx, coef_t val);
		send_request(MODE_COEF, pixel_t'($urandom), pixel_t'($urandom), pixel_t'($urandom),
			idx, val);
	endtask

	function automatic coef_t random_tap(kernel_style_t style);
		int v;
		case (style)
			KERNEL_GENTLE: v = $urandom_range(0, 1400) - 700;
			KERNEL_BLUR:   v = $urandom_range(0, 1000);
			default:       v = $urandom;
		endcase
		return coef_t'(v);
	endfunction

	task automatic program_kernel(kernel_style_t style);
		int t;
		for (t = 0; t < TAP_COUNT; t++) send_coef(t[COEF_IDX_W-1:0], random_tap(style));
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FRAME_WIDTH) width_setting = data[WIDTH_REG_W-1:0];
		if (idx == REG_FRAME_HEIGHT) height_setting = data[HEIGHT_REG_W-1:0];
		if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
			next_col = 0;
			next_row = 0;
		end
		register_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, let every outstanding pixel come back, then cover coefficient requests
	task automatic wait_pipeline_empty();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_pixels.size() != 0) begin
			$display("%0t: %0d filtered pixels never arrived", $time, pending_pixels.size());
			error_count++;
			pending_pixels.delete();
		end
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [PIXEL_BITS-1:0] want,
			logic [PIXEL_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		filtered_px_t want;
		if (in_valid && !in_ready) input_stall_cycles++;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (frame_end) frame_ends_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d end=%0b",
					$time, red_out, green_out, blue_out, frame_end);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red_out", want.red, red_out);
				check_field("green_out", want.green, green_out);
				check_field("blue_out", want.blue, blue_out);
				check_field("frame_end", want.frame_end, frame_end);
			end
		end
	end

	initial begin : drive_out_ready
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	// extreme taps, clamping at both ends, half-up rounding, taps changed mid-frame
	task automatic test_directed_kernel();
		wait_pipeline_empty();
		write_register(REG_FRAME_WIDTH, 13'd5);
		write_register(REG_FRAME_HEIGHT, 13'd3);
		send_coef(TAP_TOP_LEFT, COEF_MIN);
		send_coef(TAP_CENTRE, COEF_MAX);
		send_coef(TAP_UNUSED, COEF_MAX);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd17, 8'd200, 8'd90);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd127, 8'd1);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd1, 8'd2, 8'd3);
		// counters must hold across this request
		send_coef(TAP_BOTTOM_RIGHT, Q412_HALF);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd64, 8'd32, 8'd16);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd9, 8'd9, 8'd9);
		send_pixel(8'd1, 8'd3, 8'd2);
	endtask

	task automatic test_size_limits();
		int n;
		wait_pipeline_empty();
		program_kernel(KERNEL_GENTLE);
		send_coef(4'd9, COEF_MIN);
		wait_pipeline_empty();
		write_register(REG_FRAME_WIDTH, 13'd0);
		write_register(REG_FRAME_HEIGHT, 13'd1);
		for (n = 0; n < 4; n++) send_random_pixel();
		// spare indexes must leave geometry and position alone
		wait_pipeline_empty();
		write_register(REG_SPARE_A, 13'h1FFF);
		write_register(REG_SPARE_B, 13'h1FFF);
		for (n = 0; n < 14; n++) send_random_pixel();
		wait_pipeline_empty();
		write_register(REG_FRAME_WIDTH, 13'h1803);
		write_register(REG_FRAME_HEIGHT, 13'h1FFF);
		for (n = 0; n < 40 * K; n++) send_random_pixel();
		wait_pipeline_empty();
		write_register(REG_FRAME_WIDTH, 13'd2);
		write_register(REG_FRAME_HEIGHT, 13'd2);
		for (n = 0; n < 12; n++) send_random_pixel();
	endtask

	task automatic test_backpressure();
		int n;
		wait_pipeline_empty();
		write_register(REG_FRAME_WIDTH, 13'd8);
		write_register(REG_FRAME_HEIGHT, 13'd6);
		program_kernel(KERNEL_GENTLE);
		long_hold = 1'b1;
		for (n = 0; n < 68; n++) send_random_pixel();
		// stop mid-frame until everything is back, then finish the frame
		wait_pipeline_empty();
		for (n = 0; n < 28; n++) send_random_pixel();
	endtask

	task automatic test_random_frames();
		int done, n, total, wv, hv;
		logic [CFG_DATA_W-1:0] wdata;
		logic [COEF_IDX_W-1:0] idx;
		kernel_style_t style;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			idling = (done < RANDOM_ITEMS - CALM_ITEMS);
			wait_pipeline_empty();
			case ($urandom_range(0, 9))
				0: wv = $urandom_range(0, 2);
				1: wv = $urandom_range(13, 40);
				default: wv = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: hv = $urandom_range(0, 2);
				1: hv = $urandom_range(7, 10);
				default: hv = $urandom_range(3, 6);
			endcase
			wdata = CFG_DATA_W'(wv);
			wdata[CFG_DATA_W-1:WIDTH_REG_W] = (CFG_DATA_W - WIDTH_REG_W)'($urandom_range(0, 3));
			write_register(REG_FRAME_WIDTH, wdata);
			write_register(REG_FRAME_HEIGHT, hv[CFG_DATA_W-1:0]);
			style = kernel_style_t'($urandom_range(0, 2));
			if ($urandom_range(0, 3) != 0) begin
				program_kernel(style);
				done += TAP_COUNT;
			end
			total = $urandom_range(1, 3) * active_width() * active_height()
				+ $urandom_range(0, 2 * active_width());
			for (n = 0; n < total; n++) begin
				if ($urandom_range(0, 11) == 0) begin
					idx = COEF_IDX_W'($urandom);
					send_coef(idx, random_tap(style));
					if (idx < TAP_COUNT) done++;
				end
				send_random_pixel();
				done++;
			end
		end
	endtask

	initial begin : watchdog
		#10ms;
		$display("run timed out");
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : run_tests
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_PIXEL;
		red_in     = '0;
		green_in   = '0;
		blue_in    = '0;
		coef_index = '0;
		coef_value = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_FRAME_WIDTH;
		cfg_data   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_kernel();
		test_size_limits();
		test_backpressure();
		test_random_frames();
		wait_pipeline_empty();

		$display("Sent %0d pixels and %0d tap writes over %0d register writes, frames 3x3 to 40 wide",
			pixel_requests, coef_requests, register_writes);
		$display("Compared %0d filtered pixels (%0d frame ends), input held off %0d cycles",
			results_checked, frame_ends_seen, input_stall_cycles);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ccw_pkg.sv
hw/rtl/ccw_line_buf.sv
hw/rtl/ccw_lane.sv
hw/rtl/clamped_window_convolution.sv
hw/rtl/ccw_checker.sv
sim/tb_top.sv
